FILE: hdl/vca_pkg.sv
// shared types and constants for the virtual channel arbiter
package vca_pkg;

  // channel count and field widths, fixed by the request and result formats
  localparam int CHANNELS = 8;
  localparam int CH_W     = 3;
  localparam int WIN_W    = 4;
  localparam int CNT_W    = 4;

  // request kinds
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_PICK  = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  // arbitration policy
  localparam logic POLICY_RR   = 1'b0;
  localparam logic POLICY_FCFS = 1'b1;

  // winner code when nothing is granted
  localparam logic [WIN_W-1:0] WIN_NONE = WIN_W'(CHANNELS);

  // one request: operation and addressed channel
  typedef struct packed {
    logic [1:0]      kind;
    logic [CH_W-1:0] channel;
  } vca_op_t;

  // one result
  typedef struct packed {
    logic [WIN_W-1:0] winner;
    logic             request_bit;
    logic             error;
  } vca_res_t;

endpackage

FILE: hdl/vca_rr_pick.sv
// round-robin search: first requesting channel after the last winner
module vca_rr_pick
  import vca_pkg::*;
(
  input  logic [CHANNELS-1:0] req,
  input  logic [CH_W-1:0]     last_ptr,
  output logic                found,
  output logic [CH_W-1:0]     win
);

  // scan from last_ptr+1 round to last_ptr; the nearest hit is assigned last
  always_comb begin
    logic [CH_W-1:0] c;
    found = 1'b0;
    win   = last_ptr;
    c     = last_ptr;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      c = last_ptr + CH_W'(i + 1);
      if (req[c]) begin
        found = 1'b1;
        win   = c;
      end
    end
  end

endmodule

FILE: hdl/vca_core.sv
// arbiter state: request bits, round-robin pointer and arrival queue
module vca_core
  import vca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     policy,
  input  logic     op_fire,
  input  vca_op_t  op,
  output vca_res_t res
);

  logic [CHANNELS-1:0] req_r, req_nxt;
  logic [CH_W-1:0]     ptr_r, ptr_nxt;
  logic [CH_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CH_W-1:0]     queue_r [CHANNELS];
  logic                q_we;
  logic [CH_W-1:0]     q_waddr;
  logic                rr_found;
  logic [CH_W-1:0]     rr_win;

  vca_rr_pick u_rr_pick (
    .req      (req_r),
    .last_ptr (ptr_r),
    .found    (rr_found),
    .win      (rr_win)
  );

  // tail slot of the arrival queue
  assign q_waddr = head_r + count_r[CH_W-1:0];

  // execute one request against the current state
  always_comb begin
    req_nxt   = req_r;
    ptr_nxt   = ptr_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    q_we      = 1'b0;
    res.winner      = WIN_NONE;
    res.error       = 1'b0;
    res.request_bit = 1'b0;
    unique case (op.kind)
      KIND_SET: begin
        if (policy == POLICY_FCFS) begin
          if (req_r[op.channel]) begin
            res.error = 1'b1;
          end else begin
            req_nxt[op.channel] = 1'b1;
            if (count_r < CNT_W'(CHANNELS)) begin
              q_we      = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end else begin
          req_nxt[op.channel] = 1'b1;
        end
      end
      KIND_CLEAR: begin
        req_nxt[op.channel] = 1'b0;
      end
      KIND_PICK: begin
        if (policy == POLICY_FCFS) begin
          if (count_r != '0) begin
            res.winner = WIN_W'(queue_r[head_r]);
            head_nxt   = head_r + CH_W'(1);
            count_nxt  = count_r - CNT_W'(1);
          end
        end else if (rr_found) begin
          res.winner = WIN_W'(rr_win);
          ptr_nxt    = rr_win;
        end
      end
      KIND_QUERY: begin
      end
      default: begin
      end
    endcase
    if (op.kind != KIND_PICK) begin
      res.request_bit = req_nxt[op.channel];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r   <= '0;
      ptr_r   <= CH_W'(CHANNELS - 1);
      head_r  <= '0;
      count_r <= '0;
    end else if (op_fire) begin
      req_r   <= req_nxt;
      ptr_r   <= ptr_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // arrival queue storage, no reset: only written slots are read
  always_ff @(posedge clk) begin
    if (op_fire && q_we) begin
      queue_r[q_waddr] <= op.channel;
    end
  end

  // arrival queue count never exceeds its CHANNELS slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CHANNELS))
    else $error("arrival queue count overflow");

  // error only for an fcfs set on an already pending request
  a_error_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (op_fire && res.error) |->
      (policy == POLICY_FCFS && op.kind == KIND_SET && req_r[op.channel]))
    else $error("error flag without repeated fcfs set");

  // a round-robin pick with pending requests always grants one
  a_rr_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (op_fire && op.kind == KIND_PICK && policy == POLICY_RR && (|req_r)) |->
      (res.winner != WIN_NONE && req_r[res.winner[CH_W-1:0]]))
    else $error("round-robin pick missed a pending request");

  // fcfs pick from a non-empty queue pops exactly one entry
  a_fcfs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (op_fire && op.kind == KIND_PICK && policy == POLICY_FCFS && count_r != '0) |=>
      (count_r == $past(count_r) - CNT_W'(1)))
    else $error("fcfs pick did not pop the queue");

endmodule

FILE: hdl/virtual_channel_arbiter_core.sv
// Result path: an accepted request waits in the input register, then its result loads the result register.
// Throughput: one request per cycle unless the result side stalls; the state update for a request
// completes in the same cycle as its result register load, so the next request sees it at once.
// Reset (rst_n, synchronous, active low): request bits clear, round-robin pointer at
// the last channel, arrival queue empty, policy round-robin, both stages empty.
// top level: stream handshake, input and result registers, policy register
module virtual_channel_arbiter_core
  import vca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // policy: 0 round-robin, 1 first-come-first-serve
  // request channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [2:0] channel, [7:3] zero
  input  logic [1:0] in_tuser,      // [1:0] kind
  // result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata      // [3:0] winner, [4] request_bit, [5] error, [7:6] zero
);

  logic     policy_r;
  logic     in_valid_r;
  vca_op_t  in_op_r;
  logic     out_valid_r;
  vca_res_t out_res_r;
  vca_res_t core_res;
  logic     advance;
  logic     op_fire;

  // result stage can take a new value
  assign advance   = !out_valid_r || out_tready;
  assign op_fire   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // policy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_RR;
    end else if (cfg_wr_en) begin
      policy_r <= cfg_wr_data;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r.kind    <= in_tuser;
      in_op_r.channel <= in_tdata[CH_W-1:0];
    end
  end

  vca_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .policy  (policy_r),
    .op_fire (op_fire),
    .op      (in_op_r),
    .res     (core_res)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (op_fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.error, out_res_r.request_bit, out_res_r.winner};

endmodule

FILE: tb/vca_grant_checker.sv
// grant predictor and result checker for the virtual channel arbiter
module vca_grant_checker
  import vca_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,     // [2:0] channel, [7:3] zero
  input  logic [1:0]  in_tuser,     // [1:0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,    // [3:0] winner, [4] request_bit, [5] error, [7:6] zero
  output int unsigned pending,
  output int unsigned failures
);

  // results owed by the block, oldest first, in a small ring
  localparam int unsigned DUE_DEPTH = 16;
  vca_res_t   grants_due [DUE_DEPTH];
  logic [3:0] due_wr;
  logic [3:0] due_rd;

  // mirror of the arbiter state
  logic [CHANNELS-1:0] req_mask;
  logic [CH_W-1:0]     rr_last;
  logic [CH_W-1:0]     arrivals [CHANNELS];
  logic [CH_W-1:0]     arr_head;
  logic [CNT_W-1:0]    arr_count;
  logic                policy;

  // apply one request to the mirror and return the result it owes
  function automatic vca_res_t arbitrate(input vca_op_t op);
    vca_res_t        r;
    logic [CH_W-1:0] c;
    logic [CH_W-1:0] slot;
    r.winner      = WIN_NONE;
    r.request_bit = 1'b0;
    r.error       = 1'b0;
    case (op.kind)
      KIND_SET: begin
        if (policy == POLICY_FCFS) begin
          if (req_mask[op.channel]) begin
            r.error = 1'b1;
          end else begin
            req_mask[op.channel] = 1'b1;
            // arrival dropped once the queue is full
            if (arr_count < CHANNELS) begin
              slot = arr_head + arr_count[CH_W-1:0];
              arrivals[slot] = op.channel;
              arr_count++;
            end
          end
        end else begin
          req_mask[op.channel] = 1'b1;
        end
      end
      KIND_CLEAR: begin
        req_mask[op.channel] = 1'b0;
      end
      KIND_PICK: begin
        if (policy == POLICY_FCFS) begin
          // oldest arrival wins, whatever its bit holds now
          if (arr_count != 0) begin
            r.winner = WIN_W'(arrivals[arr_head]);
            arr_head++;
            arr_count--;
          end
        end else begin
          // first requester after the last winner, wrapping
          for (int k = 1; k <= CHANNELS; k++) begin
            c = rr_last + CH_W'(k);
            if (req_mask[c] && r.winner == WIN_NONE) r.winner = WIN_W'(c);
          end
          if (r.winner != WIN_NONE) rr_last = r.winner[CH_W-1:0];
        end
      end
      default: ;
    endcase
    if (op.kind != KIND_PICK) r.request_bit = req_mask[op.channel];
    return r;
  endfunction

  // watch both channels and the policy port
  always @(posedge clk) begin
    vca_res_t   got;
    vca_res_t   want;
    vca_op_t    op;
    logic [3:0] due_used;
    if (!rst_n) begin
      req_mask  = '0;
      rr_last   = CH_W'(CHANNELS - 1);
      arr_head  = '0;
      arr_count = '0;
      policy    = POLICY_RR;
      due_wr    = '0;
      due_rd    = '0;
      failures  = 0;
      pending  <= 0;
    end else begin
      // compare an accepted result with the oldest one owed
      if (out_tvalid && out_tready) begin
        got.winner      = out_tdata[3:0];
        got.request_bit = out_tdata[4];
        got.error       = out_tdata[5];
        if (due_wr == due_rd) begin
          $error("unexpected result, tdata %h", out_tdata);
          failures++;
        end else begin
          want = grants_due[due_rd];
          due_rd++;
          if (got.winner != want.winner) begin
            $error("winner: expected %0d, got %0d", want.winner, got.winner);
            failures++;
          end
          if (got.request_bit != want.request_bit) begin
            $error("request_bit: expected %0d, got %0d", want.request_bit, got.request_bit);
            failures++;
          end
          if (got.error != want.error) begin
            $error("error: expected %0d, got %0d", want.error, got.error);
            failures++;
          end
        end
      end
      // predict an accepted request
      if (in_tvalid && in_tready) begin
        op.kind    = in_tuser;
        op.channel = in_tdata[CH_W-1:0];
        grants_due[due_wr] = arbitrate(op);
        due_wr++;
      end
      if (cfg_wr_en) policy = cfg_wr_data;
      due_used = due_wr - due_rd;
      pending <= {28'd0, due_used};
    end
  end

endmodule

FILE: tb/virtual_channel_arbiter_core_tb.sv
// stimulus, clock, reset and verdict for the virtual channel arbiter
module virtual_channel_arbiter_core_tb;
  import vca_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'd0;   // [2:0] channel, [7:3] zero
  logic [1:0]  in_tuser    = KIND_SET;  // [1:0] kind
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;   // [3:0] winner, [4] request_bit, [5] error, [7:6] zero
  int unsigned pending;
  int unsigned failures;
  int unsigned cycles      = 0;
  bit          src_calm    = 1'b0;

  virtual_channel_arbiter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  vca_grant_checker grant_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .pending    (pending),
    .failures   (failures)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side stalls
  initial begin : sink_side
    int unsigned stall;
    bit          sink_calm;
    sink_calm = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      stall = idle_len(sink_calm);
      if (stall == 0) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // one request, held until accepted, then an optional gap
  task automatic send_req(input logic [1:0] kind, input logic [CH_W-1:0] ch);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(8-CH_W){1'b0}}, ch};
    do @(posedge clk); while (!in_tready);
    gap = idle_len(src_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every owed result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_policy(input logic p);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // random traffic, pick rate and source idling changed every 20 requests
  task automatic random_phase(input int unsigned n);
    int unsigned pick_pct;
    int unsigned r;
    logic [CH_W-1:0] ch;
    pick_pct = 30;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 2))
          0:       pick_pct = 5;
          1:       pick_pct = 30;
          default: pick_pct = 60;
        endcase
        src_calm = ($urandom_range(0, 4) == 0);
      end
      r  = $urandom_range(0, 99);
      ch = CH_W'($urandom_range(0, CHANNELS - 1));
      if (r < pick_pct) begin
        send_req(KIND_PICK, ch);
      end else begin
        case ($urandom_range(0, 3))
          0, 1:    send_req(KIND_SET, ch);
          2:       send_req(KIND_CLEAR, ch);
          default: send_req(KIND_QUERY, ch);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // round-robin: empty pick, repeat set, wrap-around
    write_policy(POLICY_RR);
    send_req(KIND_PICK, 3'd7);
    send_req(KIND_SET, 3'd0);
    send_req(KIND_SET, 3'd7);
    send_req(KIND_SET, 3'd7);
    send_req(KIND_QUERY, 3'd7);
    send_req(KIND_PICK, 3'd5);
    send_req(KIND_PICK, 3'd0);
    send_req(KIND_PICK, 3'd2);
    send_req(KIND_CLEAR, 3'd0);
    send_req(KIND_PICK, 3'd1);
    drain();

    // fcfs: repeated set flagged, cleared channel still granted, empty queue
    write_policy(POLICY_FCFS);
    send_req(KIND_SET, 3'd3);
    send_req(KIND_SET, 3'd3);
    send_req(KIND_CLEAR, 3'd3);
    send_req(KIND_PICK, 3'd6);
    send_req(KIND_PICK, 3'd4);
    // fill the queue, then a set that finds it full
    for (int c = 0; c < CHANNELS - 1; c++) send_req(KIND_SET, CH_W'(c));
    send_req(KIND_CLEAR, 3'd7);
    send_req(KIND_SET, 3'd7);
    send_req(KIND_CLEAR, 3'd2);
    send_req(KIND_SET, 3'd2);
    drain();

    // random phases, policy switched with state kept
    write_policy(POLICY_RR);
    random_phase(200);
    drain();
    write_policy(POLICY_FCFS);
    random_phase(200);
    drain();
    write_policy(POLICY_RR);
    random_phase(200);
    drain();
    write_policy(POLICY_FCFS);
    random_phase(200);
    drain();

    repeat (8) @(posedge clk);
    if (failures == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
hdl/vca_pkg.sv
hdl/vca_rr_pick.sv
hdl/vca_core.sv
hdl/virtual_channel_arbiter_core.sv
tb/vca_grant_checker.sv
tb/virtual_channel_arbiter_core_tb.sv
